>>> hdl/ipv4_header_ingress_filter_core_defines.svh
// ----------------------------------------------------------------------------
// ipv4_header_ingress_filter_core_defines.svh
// Assertion macros shared by the filter RTL. All sample on clk and are
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef IPV4_HEADER_INGRESS_FILTER_CORE_DEFINES_SVH
`define IPV4_HEADER_INGRESS_FILTER_CORE_DEFINES_SVH

// plain property check
`define IHF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define IHF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IHF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/ihf_pkg.sv
// ----------------------------------------------------------------------------
// ihf_pkg
// Types and constants of the IPv4 header ingress filter.
// ----------------------------------------------------------------------------
package ihf_pkg;

    // verdict codes
    typedef enum logic [2:0] {
        VERDICT_UDP_ACCEPT  = 3'd0,
        VERDICT_ICMP_ACCEPT = 3'd1,
        VERDICT_BAD_VERSION = 3'd2,
        VERDICT_SHORT_IHL   = 3'd3,
        VERDICT_ADDR_MISS   = 3'd4,
        VERDICT_CKSUM_BAD   = 3'd5,
        VERDICT_UNKNOWN     = 3'd6
    } verdict_t;

    // header constants
    localparam logic [3:0] IPV4_VER   = 4'd4;
    localparam logic [3:0] MIN_IHL    = 4'd5;
    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    // word positions within the header
    localparam logic [4:0] IDX_PROTO  = 5'd4;
    localparam logic [4:0] IDX_CKSUM  = 5'd5;
    localparam logic [4:0] IDX_SRC_HI = 5'd6;
    localparam logic [4:0] IDX_SRC_LO = 5'd7;
    localparam logic [4:0] IDX_DST_HI = 5'd8;
    localparam logic [4:0] IDX_DST_LO = 5'd9;

    // register map (word index = paddr[2])
    localparam logic REG_OWN_ADDR = 1'b0;

    // one result beat
    typedef struct packed {
        logic [4:0]  hdr_words;
        logic [31:0] src_addr;
        logic [7:0]  protocol;
        verdict_t    verdict;
    } result_t;

endpackage

>>> hdl/ihf_cfg_regs.sv
// ----------------------------------------------------------------------------
// ihf_cfg_regs
// APB register file: holds this station's IPv4 address.
// ----------------------------------------------------------------------------
module ihf_cfg_regs
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [31:0] own_addr
);

    logic [31:0] own_addr_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_addr_reg <= 32'd0;
        end
        else if (wr_en && (paddr[2] == ihf_pkg::REG_OWN_ADDR))
        begin
            own_addr_reg <= pwdata;
        end
    end

    // read mux; low address bits ignored
    always_comb
    begin
        unique case (paddr[2])
            ihf_pkg::REG_OWN_ADDR: prdata = own_addr_reg;
            default:               prdata = 32'd0;
        endcase
    end

    assign own_addr = own_addr_reg;

endmodule

>>> hdl/ihf_parser.sv
// ----------------------------------------------------------------------------
// ihf_parser
// Input register plus header parse state. Captures fields, keeps the
// ones-complement sum and forms the verdict for the registered word.
// ----------------------------------------------------------------------------
`include "ipv4_header_ingress_filter_core_defines.svh"

module ihf_parser
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [15:0]      s_tdata,
    input  logic             s_tuser,
    input  logic             adv,
    input  logic [31:0]      own_addr,
    output logic             res_valid,
    output ihf_pkg::result_t res
);

    // input register
    logic        in_valid_reg;
    logic [15:0] word_reg;
    logic        start_reg;

    // parse state
    logic        active_reg,  active_next;
    logic [4:0]  widx_reg,    widx_next;
    logic [4:0]  len_reg,     len_next;
    logic [15:0] sum_reg,     sum_next;
    logic [15:0] chk_reg,     chk_next;
    logic [7:0]  proto_reg,   proto_next;
    logic [31:0] src_reg,     src_next;
    logic [31:0] dst_reg,     dst_next;

    logic        step;

    assign s_tready = !in_valid_reg || adv;
    assign step     = in_valid_reg && adv;

    // input beat capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            word_reg  <= s_tdata;
            start_reg <= s_tuser;
        end
    end

    // parse step for the registered word
    always_comb
    begin
        logic [3:0]  ver;
        logic [3:0]  ihl;
        logic        early;
        logic        done;
        logic        run;
        logic [4:0]  idx;
        logic [16:0] sum_add;
        ihf_pkg::verdict_t vd;

        ver   = word_reg[15:12];
        ihl   = word_reg[11:8];
        early = 1'b0;
        vd    = ihf_pkg::VERDICT_UNKNOWN;

        // start restarts from cleared state
        if (start_reg)
        begin
            idx       = 5'd0;
            sum_next  = 16'd0;
            chk_next  = 16'd0;
            proto_next = 8'd0;
            src_next  = 32'd0;
            dst_next  = 32'd0;
            len_next  = {ihl, 1'b0};
            run       = 1'b1;
            if (ver != ihf_pkg::IPV4_VER)
            begin
                early = 1'b1;
                vd    = ihf_pkg::VERDICT_BAD_VERSION;
            end
            else if (ihl < ihf_pkg::MIN_IHL)
            begin
                early = 1'b1;
                vd    = ihf_pkg::VERDICT_SHORT_IHL;
            end
        end
        else
        begin
            idx        = widx_reg;
            sum_next   = sum_reg;
            chk_next   = chk_reg;
            proto_next = proto_reg;
            src_next   = src_reg;
            dst_next   = dst_reg;
            len_next   = len_reg;
            run        = active_reg;
        end

        // field capture and running sum
        sum_add = {1'b0, sum_next} + {1'b0, word_reg};
        if (run && !early)
        begin
            case (idx)
                ihf_pkg::IDX_PROTO:  proto_next = word_reg[7:0];
                ihf_pkg::IDX_SRC_HI: src_next[31:16] = word_reg;
                ihf_pkg::IDX_SRC_LO: src_next[15:0]  = word_reg;
                ihf_pkg::IDX_DST_HI: dst_next[31:16] = word_reg;
                ihf_pkg::IDX_DST_LO: dst_next[15:0]  = word_reg;
                default: ;
            endcase
            if (idx == ihf_pkg::IDX_CKSUM)
            begin
                chk_next = word_reg;
            end
            else
            begin
                sum_next = sum_add[15:0] + {15'd0, sum_add[16]};
            end
        end

        done = ({1'b0, idx} + 6'd1) >= {1'b0, len_next};

        // final checks in order
        if (!early)
        begin
            if (dst_next != own_addr)
                vd = ihf_pkg::VERDICT_ADDR_MISS;
            else if (~sum_next != chk_next)
                vd = ihf_pkg::VERDICT_CKSUM_BAD;
            else if (proto_next == ihf_pkg::PROTO_UDP)
                vd = ihf_pkg::VERDICT_UDP_ACCEPT;
            else if (proto_next == ihf_pkg::PROTO_ICMP)
                vd = ihf_pkg::VERDICT_ICMP_ACCEPT;
            else
                vd = ihf_pkg::VERDICT_UNKNOWN;
        end

        res_valid = in_valid_reg && (early || (run && done));
        widx_next = early ? 5'd0 : (run ? idx + 5'd1 : widx_reg);
        active_next = run && !early && !done;

        res.verdict   = vd;
        res.protocol  = proto_next;
        res.src_addr  = src_next;
        res.hdr_words = len_next;
    end

    // state update on every advancing beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            widx_reg   <= 5'd0;
            len_reg    <= 5'd0;
            sum_reg    <= 16'd0;
            chk_reg    <= 16'd0;
            proto_reg  <= 8'd0;
            src_reg    <= 32'd0;
            dst_reg    <= 32'd0;
        end
        else if (step)
        begin
            active_reg <= active_next;
            widx_reg   <= widx_next;
            len_reg    <= len_next;
            sum_reg    <= sum_next;
            chk_reg    <= chk_next;
            proto_reg  <= proto_next;
            src_reg    <= src_next;
            dst_reg    <= dst_next;
        end
    end

    // checks
    `IHF_ASSERT_IMP(a_res_needs_beat, res_valid, in_valid_reg, "result without a beat")
    `IHF_ASSERT_NXT(a_res_ends_hdr, step && res_valid, !active_reg, "header still open after verdict")
    `IHF_ASSERT_IMP(a_idx_in_hdr, active_reg, widx_reg < len_reg, "word index past header length")
    `IHF_ASSERT_IMP(a_len_min, active_reg, len_reg >= 5'd10, "open header shorter than minimum")

endmodule

>>> hdl/ihf_out_reg.sv
// ----------------------------------------------------------------------------
// ihf_out_reg
// Result register on the master side. Holds a beat while the sink stalls.
// ----------------------------------------------------------------------------
module ihf_out_reg
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             res_valid,
    input  ihf_pkg::result_t res,
    output logic             adv,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [47:0]      m_tdata
);

    logic             valid_reg;
    ihf_pkg::result_t data_reg;

    assign adv = !valid_reg || m_tready;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= res_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (adv && res_valid)
        begin
            data_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

>>> hdl/ipv4_header_ingress_filter_core.sv
// ----------------------------------------------------------------------------
// ipv4_header_ingress_filter_core
// IPv4 header check: version, IHL, destination address, header checksum and
// protocol class, with the source address passed on for ARP learning.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries header words: s_tdata is one 16-bit word in network
//   order, s_tuser high marks the first word of a header (restarts parsing).
//   Words with s_tuser low outside a header are dropped.
//   Master stream carries one verdict beat per header: at the last header
//   word, or on the first word for a bad version or an IHL below 5.
//   APB port writes own_addr at address 0.
// Throughput: one word per cycle without stalls; the parse state updates once
//   per word in a single pass between the input and result registers.
// Path: an accepted word is parsed from the input register, and its verdict
//   beat is loaded into the result register behind m_tvalid once it is free.
// Reset: clears the input and result valid flags, the parse state and
//   own_addr; the block comes up idle, outside any header.
// Stall: while m_tvalid is high and m_tready low the result register holds,
//   the input register holds its word and s_tready drops once it is full.
// ----------------------------------------------------------------------------
module ipv4_header_ingress_filter_core
(
    input  logic        clk,
    input  logic        rst_n,
    // slave stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] hdr_word
    input  logic        s_tuser,   // [0] start_req
    // master stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [2:0] verdict, [10:3] protocol,
                                   // [42:11] src_addr, [47:43] hdr_words
    // APB
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [31:0]      own_addr;
    logic             adv;
    logic             res_valid;
    ihf_pkg::result_t res;

    // configuration
    ihf_cfg_regs u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .own_addr (own_addr)
    );

    // parse stage
    ihf_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .adv       (adv),
        .own_addr  (own_addr),
        .res_valid (res_valid),
        .res       (res)
    );

    // result register
    ihf_out_reg u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .adv       (adv),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

>>> test/tb_ipv4_header_ingress_filter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ipv4_header_ingress_filter_core
// Self-checking bench for the IPv4 header ingress filter. Header words go in
// on the slave stream. Each beat that is taken is run through an in-bench
// model of the parser, and the verdicts it predicts are queued. Every verdict
// beat on the master stream is checked field by field against the oldest
// prediction. Both streams idle at random, the receiver stalls hard once, and
// the station address is changed between phases over APB.
// ----------------------------------------------------------------------------
module tb_ipv4_header_ingress_filter_core;

    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 10;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // [15:0] hdr_word
    logic        s_tuser  = 1'b0; // [0] start_req
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;         // [2:0] verdict, [10:3] protocol,
                                  // [42:11] src_addr, [47:43] hdr_words
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // idling controls and receiver hold-off requests
    bit tx_gaps = 1'b1;
    bit rx_gaps = 1'b1;
    int stall_req    = 0;
    int stall_served = 0;
    int hold_left    = 0;

    int unsigned words_sent = 0;
    int unsigned mismatches = 0;
    int unsigned idle_cycles = 0;

    // predicted verdict beats, oldest first
    ihf_pkg::result_t pending_verdicts[$];

    // parser model state
    logic [31:0] p_own    = '0;
    logic        p_active = 1'b0;
    logic [4:0]  p_idx    = '0;
    logic [4:0]  p_len    = '0;
    logic [15:0] p_sum    = '0;
    logic [15:0] p_cksum  = '0;
    logic [7:0]  p_proto  = '0;
    logic [31:0] p_src    = '0;
    logic [31:0] p_dst    = '0;

    ipv4_header_ingress_filter_core u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------
    task automatic push_verdict(input ihf_pkg::verdict_t v);
        ihf_pkg::result_t r;
        r.verdict   = v;
        r.protocol  = p_proto;
        r.src_addr  = p_src;
        r.hdr_words = p_len;
        pending_verdicts.push_back(r);
        p_active = 1'b0;
    endtask

    task automatic filter_predict(input logic [15:0] w, input logic start);
        logic [4:0]  idx;
        logic [16:0] t;
        if (start)
        begin
            p_idx    = '0;
            p_sum    = '0;
            p_cksum  = '0;
            p_proto  = '0;
            p_src    = '0;
            p_dst    = '0;
            p_len    = {w[11:8], 1'b0};
            p_active = 1'b1;
            if (w[15:12] != ihf_pkg::IPV4_VER)
            begin
                push_verdict(ihf_pkg::VERDICT_BAD_VERSION);
                return;
            end
            if (w[11:8] < ihf_pkg::MIN_IHL)
            begin
                push_verdict(ihf_pkg::VERDICT_SHORT_IHL);
                return;
            end
        end
        else if (!p_active)
            return;

        idx = p_idx;
        case (idx)
            ihf_pkg::IDX_PROTO:  p_proto       = w[7:0];
            ihf_pkg::IDX_SRC_HI: p_src[31:16]  = w;
            ihf_pkg::IDX_SRC_LO: p_src[15:0]   = w;
            ihf_pkg::IDX_DST_HI: p_dst[31:16]  = w;
            ihf_pkg::IDX_DST_LO: p_dst[15:0]   = w;
            default: ;
        endcase
        // ones-complement sum of every word but the checksum, carry folded back
        if (idx == ihf_pkg::IDX_CKSUM)
            p_cksum = w;
        else
        begin
            t     = {1'b0, p_sum} + {1'b0, w};
            p_sum = t[15:0] + {15'd0, t[16]};
        end
        p_idx = idx + 5'd1;
        if (int'(idx) + 1 < int'(p_len))
            return;

        if (p_dst != p_own)
            push_verdict(ihf_pkg::VERDICT_ADDR_MISS);
        else if (~p_sum != p_cksum)
            push_verdict(ihf_pkg::VERDICT_CKSUM_BAD);
        else if (p_proto == ihf_pkg::PROTO_UDP)
            push_verdict(ihf_pkg::VERDICT_UDP_ACCEPT);
        else if (p_proto == ihf_pkg::PROTO_ICMP)
            push_verdict(ihf_pkg::VERDICT_ICMP_ACCEPT);
        else
            push_verdict(ihf_pkg::VERDICT_UNKNOWN);
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // one word beat on the slave stream, with random idle cycles first if tx_gaps
    task automatic send_word(input logic [15:0] w, input logic start);
        while (tx_gaps && $urandom_range(0, 99) < 25)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        s_tuser  <= start;
        do
            @(posedge clk);
        while (!s_tready);
        words_sent++;
        filter_predict(w, start);
    endtask

    // builds a header with random filler and sends its first n_send words
    // (all of them when n_send is out of range)
    task automatic send_header(input logic [3:0] ver, input logic [3:0] ihl,
                               input logic [7:0] proto, input logic [31:0] src,
                               input logic [31:0] dst, input bit cksum_ok,
                               input int n_send);
        logic [15:0] hw [0:29];
        logic [16:0] t;
        logic [15:0] s;
        int n;
        int i;
        n = (ihl < ihf_pkg::MIN_IHL) ? 10 : int'(ihl) * 2;
        for (i = 0; i < 30; i++)
            hw[i] = 16'($urandom);
        hw[0]      = {ver, ihl, hw[0][7:0]};
        hw[4][7:0] = proto;
        hw[6]      = src[31:16];
        hw[7]      = src[15:0];
        hw[8]      = dst[31:16];
        hw[9]      = dst[15:0];
        s = '0;
        for (i = 0; i < n; i++)
        begin
            if (i != 5)
            begin
                t = {1'b0, s} + {1'b0, hw[i]};
                s = t[15:0] + {15'd0, t[16]};
            end
        end
        hw[5] = ~s;
        if (!cksum_ok)
            hw[5] = hw[5] ^ 16'($urandom_range(1, 65535));
        if (n_send <= 0 || n_send > n)
            n_send = n;
        for (i = 0; i < n_send; i++)
            send_word(hw[i], i == 0);
    endtask

    // let every predicted beat come out, then let the pipeline empty
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write of own_addr, then read it back
    task automatic set_station_addr(input logic [31:0] addr);
        logic [31:0] readback;
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {ihf_pkg::REG_OWN_ADDR, 2'b00};
        pwdata  <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        p_own = addr;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== addr)
        begin
            $display("%0t own_addr readback mismatch: expected %h, actual %h",
                     $time, addr, readback);
            mismatches++;
        end
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // register extremes, ending on a normal station address
    task automatic test_register_access();
        set_station_addr(32'hFFFF_FFFF);
        set_station_addr(32'h0000_0000);
        set_station_addr(32'hC0A8_0001);
    endtask

    // one full header for each verdict class that needs the whole header
    task automatic test_verdict_classes();
        send_header(ihf_pkg::IPV4_VER, ihf_pkg::MIN_IHL, ihf_pkg::PROTO_UDP,
                    32'hFFFF_FFFF, p_own, 1'b1, 0);
        send_header(ihf_pkg::IPV4_VER, ihf_pkg::MIN_IHL, ihf_pkg::PROTO_ICMP,
                    32'h0000_0000, p_own, 1'b1, 0);
        send_header(ihf_pkg::IPV4_VER, ihf_pkg::MIN_IHL, 8'hFF,
                    $urandom, p_own, 1'b1, 0);
        send_header(ihf_pkg::IPV4_VER, ihf_pkg::MIN_IHL, ihf_pkg::PROTO_UDP,
                    $urandom, ~p_own, 1'b1, 0);
        send_header(ihf_pkg::IPV4_VER, ihf_pkg::MIN_IHL, ihf_pkg::PROTO_ICMP,
                    $urandom, p_own, 1'b0, 0);
    endtask

    // verdict on the first word: bad version and short header length
    task automatic test_early_verdicts();
        send_word(16'h0000, 1'b1);
        send_word(16'hFFFF, 1'b1);
        send_word(16'h4000, 1'b1);
        send_word(16'h44FF, 1'b1);
        // follow-on word after an early verdict is dropped
        send_word(16'h1234, 1'b0);
    endtask

    // stray words while idle, and a restart in the middle of a header
    task automatic test_framing();
        send_word(16'hFFFF, 1'b0);
        send_word(16'h0000, 1'b0);
        send_header(ihf_pkg::IPV4_VER, 4'd6, ihf_pkg::PROTO_UDP, $urandom, p_own,
                    1'b1, 5);
        send_header(ihf_pkg::IPV4_VER, 4'd6, ihf_pkg::PROTO_UDP, $urandom, p_own,
                    1'b1, 0);
    endtask

    // receiver holds off while the sender keeps pushing verdict-heavy traffic
    task automatic test_backpressure();
        int k;
        tx_gaps = 1'b0;
        stall_req++;
        for (k = 0; k < 12; k++)
            send_word({4'h6, 12'($urandom)}, 1'b1);
        send_header(ihf_pkg::IPV4_VER, ihf_pkg::MIN_IHL, ihf_pkg::PROTO_UDP,
                    $urandom, p_own, 1'b1, 0);
        send_header(ihf_pkg::IPV4_VER, 4'd15, ihf_pkg::PROTO_ICMP,
                    $urandom, p_own, 1'b1, 0);
        tx_gaps = 1'b1;
    endtask

    // mostly well-formed headers with random content, plus broken ones
    task automatic run_random_traffic(input int unsigned n_words);
        int unsigned target;
        int          pick;
        logic [3:0]  ver;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        logic [31:0] dst;
        int          k;
        target = words_sent + n_words;
        while (words_sent < target)
        begin
            pick = $urandom_range(0, 99);
            ihl  = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(6, 15))
                                               : ihf_pkg::MIN_IHL;
            k    = $urandom_range(0, 99);
            if (k < 40)
                proto = ihf_pkg::PROTO_UDP;
            else if (k < 75)
                proto = ihf_pkg::PROTO_ICMP;
            else
                proto = 8'($urandom);
            dst = p_own;
            if ($urandom_range(0, 9) == 0)
                dst = ($urandom_range(0, 1) == 0) ? (p_own ^ (32'h1 << $urandom_range(0, 31)))
                                                  : 32'($urandom);
            if (pick < 70)
                send_header(ihf_pkg::IPV4_VER, ihl, proto, $urandom, dst,
                            $urandom_range(0, 9) != 0, 0);
            else if (pick < 78)
                send_header(ihf_pkg::IPV4_VER, ihl, proto, $urandom, dst, 1'b1,
                            $urandom_range(1, int'(ihl) * 2 - 1));
            else if (pick < 86)
            begin
                ver = 4'($urandom_range(0, 15));
                if (ver == ihf_pkg::IPV4_VER)
                    ver = 4'hF;
                send_header(ver, 4'($urandom_range(0, 15)), proto, $urandom, dst, 1'b1,
                            $urandom_range(1, 3));
            end
            else if (pick < 93)
                send_header(ihf_pkg::IPV4_VER, 4'($urandom_range(0, 4)), proto,
                            $urandom, dst, 1'b1, $urandom_range(1, 2));
            else
            begin
                for (k = $urandom_range(1, 4); k > 0; k--)
                    send_word(16'($urandom), 1'b0);
            end
        end
    endtask

    task automatic test_random();
        run_random_traffic(250);
        set_station_addr(32'hFFFF_FFFF);
        // stretch with no idling on either side
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        run_random_traffic(250);
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        set_station_addr(32'h0000_0000);
        run_random_traffic(250);
        set_station_addr($urandom);
        run_random_traffic(250);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_register_access();
        test_verdict_classes();
        test_early_verdicts();
        test_framing();
        test_backpressure();
        test_random();
        drain_results();
        if (mismatches == 0 && pending_verdicts.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // receiver: random idling, plus long hold-offs on request
    always @(posedge clk)
    begin
        if (stall_served != stall_req)
        begin
            stall_served = stall_req;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= !rx_gaps || ($urandom_range(0, 99) >= 25);
    end

    // verdict beat checker
    always @(posedge clk)
    begin
        ihf_pkg::result_t got;
        ihf_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (pending_verdicts.size() == 0)
            begin
                $display("%0t unexpected verdict beat: expected none, actual %h",
                         $time, m_tdata);
                mismatches++;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (got.verdict !== want.verdict)
                begin
                    $display("%0t verdict mismatch: expected %0d, actual %0d",
                             $time, want.verdict, got.verdict);
                    mismatches++;
                end
                if (got.protocol !== want.protocol)
                begin
                    $display("%0t protocol mismatch: expected %h, actual %h",
                             $time, want.protocol, got.protocol);
                    mismatches++;
                end
                if (got.src_addr !== want.src_addr)
                begin
                    $display("%0t src_addr mismatch: expected %h, actual %h",
                             $time, want.src_addr, got.src_addr);
                    mismatches++;
                end
                if (got.hdr_words !== want.hdr_words)
                begin
                    $display("%0t hdr_words mismatch: expected %0d, actual %0d",
                             $time, want.hdr_words, got.hdr_words);
                    mismatches++;
                end
            end
        end
    end

    // watchdog: too long with no beat on either stream
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t watchdog: no beat for %0d cycles", $time, idle_cycles);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

endmodule
